FILE: hw/rtl/ikv_pkg.sv
// Package for the indentation key/value lexer: shared types, codes and defaults.
// Used by the channel interfaces' users, the front, the queue, the back and the top level.
// Depends on nothing.
package ikv_pkg;

    localparam int MAX_INDENT_DEFAULT  = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int MAX_RESULTS         = 20;
    localparam logic [3:0] SPL_RESET   = 4'd2;

    typedef enum logic [3:0] {
        TK_NEWLINE = 4'd0,
        TK_COLON   = 4'd1,
        TK_STR     = 4'd2,
        TK_STRCON  = 4'd3,
        TK_UP      = 4'd4,
        TK_DOWN    = 4'd5,
        TK_BULLET  = 4'd6,
        TK_BYTE    = 4'd7,
        TK_END     = 4'd8
    } token_kind_t;

    typedef enum logic [2:0] {
        CL_OTHER,
        CL_SPACE,
        CL_NEWLINE,
        CL_COLON,
        CL_HASH,
        CL_DASH,
        CL_BSLASH
    } byte_class_t;

    typedef enum logic [1:0] {
        LM_LINE,
        LM_BULLET,
        LM_TOP,
        LM_COMMENT
    } line_mode_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_HANDLE,
        BK_ESC2,
        BK_INDENT,
        BK_DECIDE,
        BK_EOT_RES,
        BK_EOT_END,
        BK_FINISH
    } bk_state_t;

    // One classified input word as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]  text_byte;
        byte_class_t cls;
        logic        end_of_text;
    } q_entry_t;

endpackage

FILE: hw/rtl/ikv_if.sv
// Channel interfaces of the indentation key/value lexer: text in, tokens out.
// Valid/ready handshake; a word moves when both are high at a rising edge.
// Depends on nothing.
interface ikv_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ikv_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] content_value;
    logic       run_last;

    modport source (output valid, output token_kind, output content_value,
                    output run_last, input ready);
    modport sink   (input valid, input token_kind, input content_value,
                    input run_last, output ready);
endinterface

FILE: hw/rtl/ikv_front.sv
// Front of the lexer: takes text words and classifies each byte for the back.
// Depends on ikv_pkg and ikv_text_if.
module ikv_front (
    ikv_text_if.sink          text,
    input  logic              q_full,
    output logic              push,
    output ikv_pkg::q_entry_t push_entry
);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    function automatic ikv_pkg::byte_class_t classify(input logic [7:0] b);
        ikv_pkg::byte_class_t c;
        case (b)
            CH_NEWLINE: c = ikv_pkg::CL_NEWLINE;
            CH_SPACE:   c = ikv_pkg::CL_SPACE;
            CH_HASH:    c = ikv_pkg::CL_HASH;
            CH_DASH:    c = ikv_pkg::CL_DASH;
            CH_COLON:   c = ikv_pkg::CL_COLON;
            CH_BSLASH:  c = ikv_pkg::CL_BSLASH;
            default:    c = ikv_pkg::CL_OTHER;
        endcase
        return c;
    endfunction

    assign text.ready = !q_full;
    assign push       = text.valid && !q_full;

    always_comb
    begin
        push_entry.text_byte   = text.text_byte;
        push_entry.cls         = classify(text.text_byte);
        push_entry.end_of_text = text.end_of_text;
    end

endmodule

FILE: hw/rtl/ikv_queue.sv
// Short first-in first-out queue of classified words between front and back.
// Depends on ikv_pkg.
module ikv_queue #(
    parameter int DEPTH = ikv_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ikv_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output ikv_pkg::q_entry_t head,
    output logic              head_valid
);

    // DEPTH must be at least two.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ikv_pkg::q_entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/ikv_back.sv
// Back of the lexer: sequencer that runs the tokenizing rules on queued words,
// holds the lookahead and parse state, and drives the token output register.
// Depends on ikv_pkg and ikv_token_if.
module ikv_back #(
    parameter int MAX_INDENT = ikv_pkg::MAX_INDENT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        spaces_per_level,
    input  ikv_pkg::q_entry_t head,
    input  logic              head_valid,
    output logic              pop,
    ikv_token_if.source       token
);

    localparam int LVL_W  = $clog2(MAX_INDENT + 1);
    localparam int PROD_W = LVL_W + 5;
    localparam int CNT_W  = $clog2(ikv_pkg::MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        HR_CONT,
        HR_RET1,
        HR_RET2,
        HR_INDENT,
        HR_ESC2
    } hres_t;

    ikv_pkg::bk_state_t   state_reg, state_next;
    ikv_pkg::q_entry_t    it_reg, it_next;
    logic                 ph_b_reg, ph_b_next;
    logic                 ind_eot_reg, ind_eot_next;
    logic [7:0]           la_byte_reg, la_byte_next;
    ikv_pkg::byte_class_t la_cls_reg, la_cls_next;
    logic                 la_valid_reg, la_valid_next;
    ikv_pkg::line_mode_t  mode_reg, mode_next;
    logic                 key_reg, key_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [7:0]           sc_reg, sc_next;
    logic                 last_nl_reg, last_nl_next;
    logic                 str_reg, str_next;
    logic                 pend_valid_reg, pend_valid_next;
    ikv_pkg::token_kind_t pend_kind_reg, pend_kind_next;
    logic [7:0]           pend_val_reg, pend_val_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    ikv_pkg::token_kind_t out_kind_reg, out_kind_next;
    logic [7:0]           out_val_reg, out_val_next;
    logic                 out_last_reg, out_last_next;

    // Current byte, its successor and whether a successor exists.
    ikv_pkg::byte_class_t c_cls;
    logic [7:0]           c_byte;
    logic                 hn;
    logic                 key_colon;

    // One pass of the rule loop.
    logic                 h_emit;
    ikv_pkg::token_kind_t h_kind;
    logic [7:0]           h_val;
    hres_t                h_res;
    logic                 h_str;
    ikv_pkg::line_mode_t  h_mode;
    logic                 h_key;
    logic [7:0]           h_sc;

    // Indent resolution compares level boundaries against the space count.
    logic [3:0]           spl_eff;
    logic [PROD_W-1:0]    prod_up, prod_dn, sc_ext;
    logic                 ind_up, ind_dn;

    logic                 gen;
    ikv_pkg::token_kind_t gen_kind;
    logic [7:0]           gen_val;
    logic                 gen_keep;
    logic                 out_load_ok;
    logic                 need_push;
    logic                 adv;
    logic                 decide_b;
    ikv_pkg::bk_state_t   ret_state1, ret_state2;

    assign c_cls     = ph_b_reg ? it_reg.cls : la_cls_reg;
    assign c_byte    = ph_b_reg ? it_reg.text_byte : la_byte_reg;
    assign hn        = !ph_b_reg && !it_reg.end_of_text;
    assign key_colon = (c_cls == ikv_pkg::CL_COLON) && key_reg && hn;

    assign spl_eff = (spaces_per_level == 4'd0) ? 4'd1 : spaces_per_level;
    assign prod_up = (PROD_W'(lvl_reg) + PROD_W'(1)) * PROD_W'(spl_eff);
    assign prod_dn = PROD_W'(lvl_reg) * PROD_W'(spl_eff);
    assign sc_ext  = PROD_W'(sc_reg);
    assign ind_up  = (lvl_reg < LVL_W'(MAX_INDENT)) && (prod_up <= sc_ext);
    assign ind_dn  = !ind_up && (prod_dn > sc_ext);

    assign decide_b = !str_reg && (mode_reg == ikv_pkg::LM_LINE) &&
                      ((it_reg.cls == ikv_pkg::CL_SPACE) || (it_reg.cls == ikv_pkg::CL_NEWLINE));

    // Rule loop: one iteration per cycle while the back is not stalled.
    always_comb
    begin
        h_emit = 1'b0;
        h_kind = ikv_pkg::TK_NEWLINE;
        h_val  = 8'd0;
        h_res  = HR_RET1;
        h_str  = str_reg;
        h_mode = mode_reg;
        h_key  = key_reg;
        h_sc   = sc_reg;
        if (str_reg)
        begin
            if (c_cls == ikv_pkg::CL_BSLASH)
            begin
                h_emit = 1'b1;
                h_kind = ikv_pkg::TK_BYTE;
                if (!hn)
                begin
                    h_val = c_byte;
                    h_res = HR_RET1;
                end
                else if ((it_reg.cls == ikv_pkg::CL_COLON) || (it_reg.cls == ikv_pkg::CL_DASH) ||
                         (it_reg.cls == ikv_pkg::CL_HASH) || (it_reg.cls == ikv_pkg::CL_BSLASH))
                begin
                    h_val = it_reg.text_byte;
                    h_res = HR_RET2;
                end
                else if (it_reg.cls == ikv_pkg::CL_NEWLINE)
                begin
                    h_kind = ikv_pkg::TK_STRCON;
                    h_res  = HR_RET2;
                end
                else
                begin
                    // Unknown escape: the backslash now, the next byte in the ESC2 state.
                    h_val = c_byte;
                    h_res = HR_ESC2;
                end
            end
            else if ((c_cls == ikv_pkg::CL_NEWLINE) || (c_cls == ikv_pkg::CL_HASH) ||
                     (key_colon && ((it_reg.cls == ikv_pkg::CL_SPACE) ||
                                    (it_reg.cls == ikv_pkg::CL_NEWLINE))))
            begin
                h_str  = 1'b0;
                h_mode = ikv_pkg::LM_TOP;
                h_res  = HR_CONT;
            end
            else
            begin
                h_emit = 1'b1;
                h_kind = ikv_pkg::TK_BYTE;
                h_val  = c_byte;
                h_res  = HR_RET1;
            end
        end
        else
        begin
            case (mode_reg)
                ikv_pkg::LM_LINE:
                begin
                    if (c_cls == ikv_pkg::CL_SPACE)
                    begin
                        h_sc  = (sc_reg == 8'hFF) ? sc_reg : sc_reg + 8'd1;
                        h_res = HR_RET1;
                    end
                    else if ((c_cls == ikv_pkg::CL_NEWLINE) && (sc_reg == 8'd0) && last_nl_reg)
                    begin
                        h_res = HR_RET1;
                    end
                    else
                    begin
                        h_mode = ikv_pkg::LM_BULLET;
                        h_res  = HR_INDENT;
                    end
                end
                ikv_pkg::LM_BULLET:
                begin
                    if ((c_cls == ikv_pkg::CL_DASH) && hn && (it_reg.cls == ikv_pkg::CL_SPACE))
                    begin
                        h_emit = 1'b1;
                        h_kind = ikv_pkg::TK_BULLET;
                        h_res  = HR_RET2;
                    end
                    else
                    begin
                        h_mode = ikv_pkg::LM_TOP;
                        h_res  = HR_CONT;
                    end
                end
                ikv_pkg::LM_COMMENT:
                begin
                    if (c_cls == ikv_pkg::CL_NEWLINE)
                    begin
                        h_mode = ikv_pkg::LM_TOP;
                        h_res  = HR_CONT;
                    end
                    else
                    begin
                        h_res = HR_RET1;
                    end
                end
                ikv_pkg::LM_TOP:
                begin
                    if (c_cls == ikv_pkg::CL_NEWLINE)
                    begin
                        h_emit = !last_nl_reg;
                        h_kind = ikv_pkg::TK_NEWLINE;
                        h_mode = ikv_pkg::LM_LINE;
                        h_sc   = 8'd0;
                        h_key  = 1'b1;
                        h_res  = HR_RET1;
                    end
                    else if (key_colon && (it_reg.cls == ikv_pkg::CL_SPACE))
                    begin
                        h_emit = 1'b1;
                        h_kind = ikv_pkg::TK_COLON;
                        h_key  = 1'b0;
                        h_res  = HR_RET2;
                    end
                    else if (key_colon && (it_reg.cls == ikv_pkg::CL_NEWLINE))
                    begin
                        h_emit = 1'b1;
                        h_kind = ikv_pkg::TK_COLON;
                        h_res  = HR_RET1;
                    end
                    else if (c_cls == ikv_pkg::CL_HASH)
                    begin
                        h_mode = ikv_pkg::LM_COMMENT;
                        h_res  = HR_RET1;
                    end
                    else
                    begin
                        // Anything else, a bare colon included, opens a string.
                        h_emit = 1'b1;
                        h_kind = ikv_pkg::TK_STR;
                        h_str  = 1'b1;
                        h_res  = HR_CONT;
                    end
                end
                default:
                begin
                    h_res = HR_RET1;
                end
            endcase
        end
    end

    // Token produced in the current state.
    always_comb
    begin
        gen      = 1'b0;
        gen_kind = ikv_pkg::TK_NEWLINE;
        gen_val  = 8'd0;
        case (state_reg)
            ikv_pkg::BK_HANDLE:
            begin
                gen      = h_emit;
                gen_kind = h_kind;
                gen_val  = h_val;
            end
            ikv_pkg::BK_ESC2:
            begin
                gen      = 1'b1;
                gen_kind = ikv_pkg::TK_BYTE;
                gen_val  = it_reg.text_byte;
            end
            ikv_pkg::BK_INDENT:
            begin
                gen      = ind_up || ind_dn;
                gen_kind = ind_up ? ikv_pkg::TK_UP : ikv_pkg::TK_DOWN;
            end
            ikv_pkg::BK_EOT_END:
            begin
                gen      = 1'b1;
                gen_kind = ikv_pkg::TK_END;
            end
            default:
            begin
                gen = 1'b0;
            end
        endcase
    end

    assign gen_keep    = gen && (cnt_reg < CNT_W'(ikv_pkg::MAX_RESULTS));
    assign out_load_ok = !out_valid_reg || token.ready;
    assign need_push   = pend_valid_reg &&
                         (gen_keep || (state_reg == ikv_pkg::BK_FINISH));
    assign adv         = !need_push || out_load_ok;

    // Where a return from the rule loop leads, for a one- or two-byte return.
    assign ret_state1 = ph_b_reg ? ikv_pkg::BK_FINISH :
                        (it_reg.end_of_text ? ikv_pkg::BK_EOT_RES : ikv_pkg::BK_DECIDE);
    assign ret_state2 = ph_b_reg ? ikv_pkg::BK_FINISH :
                        (it_reg.end_of_text ? ikv_pkg::BK_EOT_RES : ikv_pkg::BK_FINISH);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (adv)
        begin
            case (state_reg)
                ikv_pkg::BK_IDLE:
                begin
                    if (head_valid)
                    begin
                        if (la_valid_reg)
                        begin
                            state_next = ikv_pkg::BK_HANDLE;
                        end
                        else if (head.end_of_text)
                        begin
                            state_next = ikv_pkg::BK_EOT_RES;
                        end
                        else
                        begin
                            state_next = ikv_pkg::BK_DECIDE;
                        end
                    end
                end
                ikv_pkg::BK_HANDLE:
                begin
                    case (h_res)
                        HR_CONT:   state_next = ikv_pkg::BK_HANDLE;
                        HR_INDENT: state_next = ikv_pkg::BK_INDENT;
                        HR_ESC2:   state_next = ikv_pkg::BK_ESC2;
                        HR_RET2:   state_next = ret_state2;
                        default:   state_next = ret_state1;
                    endcase
                end
                ikv_pkg::BK_ESC2:
                begin
                    state_next = ret_state2;
                end
                ikv_pkg::BK_INDENT:
                begin
                    if (!ind_up && !ind_dn)
                    begin
                        state_next = ind_eot_reg ? ikv_pkg::BK_EOT_END : ikv_pkg::BK_HANDLE;
                    end
                end
                ikv_pkg::BK_DECIDE:
                begin
                    state_next = decide_b ? ikv_pkg::BK_HANDLE : ikv_pkg::BK_FINISH;
                end
                ikv_pkg::BK_EOT_RES:
                begin
                    if (!str_reg && (mode_reg == ikv_pkg::LM_LINE))
                    begin
                        state_next = ikv_pkg::BK_INDENT;
                    end
                    else
                    begin
                        state_next = ikv_pkg::BK_EOT_END;
                    end
                end
                ikv_pkg::BK_EOT_END:
                begin
                    state_next = ikv_pkg::BK_FINISH;
                end
                ikv_pkg::BK_FINISH:
                begin
                    state_next = ikv_pkg::BK_IDLE;
                end
                default:
                begin
                    state_next = ikv_pkg::BK_IDLE;
                end
            endcase
        end
    end

    // Datapath and outputs.
    always_comb
    begin
        pop             = 1'b0;
        it_next         = it_reg;
        ph_b_next       = ph_b_reg;
        ind_eot_next    = ind_eot_reg;
        la_byte_next    = la_byte_reg;
        la_cls_next     = la_cls_reg;
        la_valid_next   = la_valid_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        lvl_next        = lvl_reg;
        sc_next         = sc_reg;
        last_nl_next    = last_nl_reg;
        str_next        = str_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_val_next   = pend_val_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !token.ready;
        out_kind_next   = out_kind_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;

        if (adv)
        begin
            // A new token pushes the held one out; the held one learns it was not last.
            if (gen)
            begin
                last_nl_next = (gen_kind == ikv_pkg::TK_NEWLINE);
            end
            if (gen_keep)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_val_next   = pend_val_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_kind_next  = gen_kind;
                pend_val_next   = gen_val;
                cnt_next        = cnt_reg + CNT_W'(1);
            end

            case (state_reg)
                ikv_pkg::BK_IDLE:
                begin
                    if (head_valid)
                    begin
                        pop           = 1'b1;
                        it_next       = head;
                        ph_b_next     = 1'b0;
                        ind_eot_next  = 1'b0;
                        la_valid_next = 1'b0;
                    end
                end
                ikv_pkg::BK_HANDLE:
                begin
                    str_next  = h_str;
                    mode_next = h_mode;
                    key_next  = h_key;
                    sc_next   = h_sc;
                end
                ikv_pkg::BK_INDENT:
                begin
                    if (ind_up)
                    begin
                        lvl_next = lvl_reg + LVL_W'(1);
                    end
                    else if (ind_dn)
                    begin
                        lvl_next = lvl_reg - LVL_W'(1);
                    end
                    else
                    begin
                        sc_next = 8'd0;
                    end
                end
                ikv_pkg::BK_DECIDE:
                begin
                    if (decide_b)
                    begin
                        ph_b_next = 1'b1;
                    end
                    else
                    begin
                        la_byte_next  = it_reg.text_byte;
                        la_cls_next   = it_reg.cls;
                        la_valid_next = 1'b1;
                    end
                end
                ikv_pkg::BK_EOT_RES:
                begin
                    ind_eot_next = 1'b1;
                end
                ikv_pkg::BK_EOT_END:
                begin
                    la_byte_next  = 8'd0;
                    la_valid_next = 1'b0;
                    mode_next     = ikv_pkg::LM_LINE;
                    key_next      = 1'b1;
                    lvl_next      = '0;
                    sc_next       = 8'd0;
                    last_nl_next  = 1'b0;
                    str_next      = 1'b0;
                end
                ikv_pkg::BK_FINISH:
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = pend_kind_reg;
                        out_val_next   = pend_val_reg;
                        out_last_next  = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                end
                default:
                begin
                    pop = 1'b0;
                end
            endcase
        end
    end

    assign token.valid         = out_valid_reg;
    assign token.token_kind    = out_kind_reg;
    assign token.content_value = out_val_reg;
    assign token.run_last      = out_last_reg;

    always_ff @(posedge clk)
    begin
        it_reg        <= it_next;
        pend_kind_reg <= pend_kind_next;
        pend_val_reg  <= pend_val_next;
        out_kind_reg  <= out_kind_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ikv_pkg::BK_IDLE;
            ph_b_reg       <= 1'b0;
            ind_eot_reg    <= 1'b0;
            la_byte_reg    <= 8'd0;
            la_cls_reg     <= ikv_pkg::CL_OTHER;
            la_valid_reg   <= 1'b0;
            mode_reg       <= ikv_pkg::LM_LINE;
            key_reg        <= 1'b1;
            lvl_reg        <= '0;
            sc_reg         <= 8'd0;
            last_nl_reg    <= 1'b0;
            str_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ph_b_reg       <= ph_b_next;
            ind_eot_reg    <= ind_eot_next;
            la_byte_reg    <= la_byte_next;
            la_cls_reg     <= la_cls_next;
            la_valid_reg   <= la_valid_next;
            mode_reg       <= mode_next;
            key_reg        <= key_next;
            lvl_reg        <= lvl_next;
            sc_reg         <= sc_next;
            last_nl_reg    <= last_nl_next;
            str_reg        <= str_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/indent_key_value_lexer_unit.sv
// Top level of the indentation key/value lexer: front, queue, back and the
// spaces-per-level register. Depends on ikv_pkg, ikv_if, ikv_front, ikv_queue, ikv_back.
//
// Usage. The text channel carries one word per byte of the text, or a word with
// end_of_text set that flushes the lookahead, settles a pending indent and
// yields the end token. The token channel carries one word per token; run_last
// marks the last token caused by one text word. Both channels use valid/ready and
// move a word at a rising edge where both are high.
// The front classifies each byte and writes it into a two-word queue, so text is
// taken while the back is busy. The back is a sequencer that runs one rule per
// cycle while it is not stalled: popping a word, each rule evaluation, each
// indent token, and a closing step. One byte of lookahead is held, so most
// tokens of a byte appear one text word later. A token is held back by one so
// that run_last is known when it leaves; the output register then parts the
// back from the receiver.
// When the receiver stalls, the output register holds its word, the back stops
// once its held token must move, and the queue then fills and drops ready.
// Reset empties the queue, clears the parse state to a fresh line start at
// level zero and sets spaces per level to two. The register is written with
// cfg_write_en and must only change while the block is idle.
module indent_key_value_lexer_unit #(
    parameter int MAX_INDENT  = ikv_pkg::MAX_INDENT_DEFAULT,
    parameter int QUEUE_DEPTH = ikv_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [3:0]  cfg_write_data,
    ikv_text_if.sink    text,
    ikv_token_if.source token
);

    logic [3:0] spl_reg, spl_next;

    logic              push;
    ikv_pkg::q_entry_t push_entry;
    logic              q_full;
    logic              pop;
    ikv_pkg::q_entry_t head;
    logic              head_valid;

    // Spaces-per-level register; zero is read as one by the back.
    always_comb
    begin
        spl_next = cfg_write_en ? cfg_write_data : spl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spl_reg <= ikv_pkg::SPL_RESET;
        end
        else
        begin
            spl_reg <= spl_next;
        end
    end

    ikv_front u_front (
        .text       (text),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ikv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    ikv_back #(
        .MAX_INDENT (MAX_INDENT)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .spaces_per_level (spl_reg),
        .head             (head),
        .head_valid       (head_valid),
        .pop              (pop),
        .token            (token)
    );

endmodule

FILE: sim/ikv_token_check.sv
// Token stream checker for the indentation key/value lexer: predicts every token
// from the accepted text words and compares the token channel against it.
// Depends on ikv_pkg and the channel interfaces in ikv_if.
module ikv_token_check #(
    parameter int MAX_INDENT = ikv_pkg::MAX_INDENT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [3:0] cfg_write_data,
    ikv_text_if        text,
    ikv_token_if       token,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic       last;
    } lex_token_t;

    lex_token_t tokens_due[$];
    lex_token_t step_tokens[$];
    lex_token_t seen_token;
    lex_token_t due_token;

    // Shadow of the lexer's parse state and its one register.
    logic [3:0]          spl;
    logic [7:0]          la_byte;
    bit                  la_valid;
    ikv_pkg::line_mode_t mode;
    bit                  key_part;
    int                  level;
    int                  spaces;
    bit                  last_nl;
    bit                  in_string;
    int                  fails;
    int                  seen_count;

    function automatic void put_token(ikv_pkg::token_kind_t kind, logic [7:0] value);
        lex_token_t t;
        if (step_tokens.size() < ikv_pkg::MAX_RESULTS)
        begin
            t.kind  = kind;
            t.value = value;
            t.last  = 1'b0;
            step_tokens.insert(step_tokens.size(), t);
        end
        last_nl = (kind == ikv_pkg::TK_NEWLINE);
    endfunction

    function automatic void settle_indent();
        int eff;
        int target;
        eff    = (spl == 4'd0) ? 1 : int'(spl);
        target = spaces / eff;
        if (target > MAX_INDENT)
            target = MAX_INDENT;
        while (level < target)
        begin
            put_token(ikv_pkg::TK_UP, 8'h00);
            level++;
        end
        while (level > target)
        begin
            put_token(ikv_pkg::TK_DOWN, 8'h00);
            level--;
        end
        spaces = 0;
    endfunction

    function automatic void clear_parse();
        la_byte   = 8'h00;
        la_valid  = 1'b0;
        mode      = ikv_pkg::LM_LINE;
        key_part  = 1'b1;
        level     = 0;
        spaces    = 0;
        last_nl   = 1'b0;
        in_string = 1'b0;
    endfunction

    // Works on byte c with the following byte nx when has_next is set.
    // Returns how many bytes were used up: one, or two when nx was taken too.
    function automatic int take_byte(logic [7:0] c, bit has_next, logic [7:0] nx);
        int used;
        used = 0;
        while (used == 0)
        begin
            if (in_string)
            begin
                if (c == CH_BSLASH)
                begin
                    if (!has_next)
                    begin
                        put_token(ikv_pkg::TK_BYTE, c);
                        used = 1;
                    end
                    else
                    begin
                        if (nx == CH_COLON || nx == CH_DASH || nx == CH_HASH || nx == CH_BSLASH)
                            put_token(ikv_pkg::TK_BYTE, nx);
                        else if (nx == CH_NL)
                            put_token(ikv_pkg::TK_STRCON, 8'h00);
                        else
                        begin
                            put_token(ikv_pkg::TK_BYTE, c);
                            put_token(ikv_pkg::TK_BYTE, nx);
                        end
                        used = 2;
                    end
                end
                else if (c == CH_NL || c == CH_HASH ||
                         (c == CH_COLON && key_part && has_next &&
                          (nx == CH_SPACE || nx == CH_NL)))
                begin
                    in_string = 1'b0;
                    mode      = ikv_pkg::LM_TOP;
                end
                else
                begin
                    put_token(ikv_pkg::TK_BYTE, c);
                    used = 1;
                end
            end
            else
            begin
                case (mode)
                    ikv_pkg::LM_LINE:
                    begin
                        if (c == CH_SPACE)
                        begin
                            if (spaces < 255)
                                spaces++;
                            used = 1;
                        end
                        else if (c == CH_NL && spaces == 0 && last_nl)
                            used = 1;
                        else
                        begin
                            settle_indent();
                            mode = ikv_pkg::LM_BULLET;
                        end
                    end
                    ikv_pkg::LM_BULLET:
                    begin
                        if (c == CH_DASH && has_next && nx == CH_SPACE)
                        begin
                            put_token(ikv_pkg::TK_BULLET, 8'h00);
                            used = 2;
                        end
                        else
                            mode = ikv_pkg::LM_TOP;
                    end
                    ikv_pkg::LM_COMMENT:
                    begin
                        if (c == CH_NL)
                            mode = ikv_pkg::LM_TOP;
                        else
                            used = 1;
                    end
                    default:
                    begin
                        if (c == CH_NL)
                        begin
                            if (!last_nl)
                                put_token(ikv_pkg::TK_NEWLINE, 8'h00);
                            mode     = ikv_pkg::LM_LINE;
                            spaces   = 0;
                            key_part = 1'b1;
                            used     = 1;
                        end
                        else if (c == CH_COLON && key_part && has_next && nx == CH_SPACE)
                        begin
                            put_token(ikv_pkg::TK_COLON, 8'h00);
                            key_part = 1'b0;
                            used     = 2;
                        end
                        else if (c == CH_COLON && key_part && has_next && nx == CH_NL)
                        begin
                            put_token(ikv_pkg::TK_COLON, 8'h00);
                            used = 1;
                        end
                        else if (c == CH_HASH)
                        begin
                            mode = ikv_pkg::LM_COMMENT;
                            used = 1;
                        end
                        else
                        begin
                            put_token(ikv_pkg::TK_STR, 8'h00);
                            in_string = 1'b1;
                        end
                    end
                endcase
            end
        end
        return used;
    endfunction

    // Predicts the tokens of one accepted text word and queues them.
    function automatic void lex_step(logic [7:0] b, bit eot);
        bit taken;
        step_tokens.delete();
        taken = 1'b0;
        if (eot)
        begin
            if (la_valid)
            begin
                la_valid = 1'b0;
                void'(take_byte(la_byte, 1'b0, 8'h00));
            end
            if (!in_string && mode == ikv_pkg::LM_LINE)
                settle_indent();
            put_token(ikv_pkg::TK_END, 8'h00);
            clear_parse();
        end
        else
        begin
            if (la_valid)
            begin
                la_valid = 1'b0;
                if (take_byte(la_byte, 1'b1, b) == 2)
                    taken = 1'b1;
            end
            if (!taken)
            begin
                if (!in_string && mode == ikv_pkg::LM_LINE && (b == CH_SPACE || b == CH_NL))
                    void'(take_byte(b, 1'b0, 8'h00));
                else
                begin
                    la_byte  = b;
                    la_valid = 1'b1;
                end
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            tokens_due.insert(tokens_due.size(), step_tokens[i]);
    endfunction

    function automatic void note_mismatch(bit unexpected);
        fails++;
        if (fails <= 10)
        begin
            if (unexpected)
                $display("%0t ikv_token_check: token %0d arrived with none due: %s",
                         $realtime, seen_count,
                         $sformatf("kind %0d value %02h last %0b",
                                   seen_token.kind, seen_token.value, seen_token.last));
            else
                $display("%0t ikv_token_check: token %0d expected %s, got %s",
                         $realtime, seen_count,
                         $sformatf("kind %0d value %02h last %0b",
                                   due_token.kind, due_token.value, due_token.last),
                         $sformatf("kind %0d value %02h last %0b",
                                   seen_token.kind, seen_token.value, seen_token.last));
        end
    endfunction

    // A token that leaves at an edge cannot stem from a word taken at that same
    // edge, so the comparison runs before the new prediction is queued.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spl = ikv_pkg::SPL_RESET;
            clear_parse();
            tokens_due.delete();
            fails      = 0;
            seen_count = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_write_en)
                spl = cfg_write_data;
            if (token.valid && token.ready)
            begin
                seen_token.kind  = token.token_kind;
                seen_token.value = token.content_value;
                seen_token.last  = token.run_last;
                if (tokens_due.size() == 0)
                    note_mismatch(1'b1);
                else
                begin
                    due_token = tokens_due.pop_front();
                    if (seen_token.kind !== due_token.kind ||
                        seen_token.value !== due_token.value ||
                        seen_token.last !== due_token.last)
                        note_mismatch(1'b0);
                end
                seen_count++;
            end
            if (text.valid && text.ready)
                lex_step(text.text_byte, text.end_of_text);
            fail_count <= fails;
            pending    <= tokens_due.size();
        end
    end

endmodule

FILE: sim/indent_key_value_lexer_unit_test.sv
// Testbench top for the indentation key/value lexer: drives text words and token
// back-pressure, sets spaces per level in phases, and gives the verdict.
// Depends on ikv_pkg, ikv_if, ikv_token_check and the lexer top level.
module indent_key_value_lexer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEX_MAX_INDENT         = 16;
    // Cycles to let pass once no token is due, so that a word that makes no
    // token has surely left the block, a line start with its indent tokens included.
    localparam int SETTLE_CYCLES          = 80;
    // Long receiver stall: far longer than the queue and the output register
    // can cover, so the text channel must drop ready.
    localparam int HOLD_CYCLES            = 400;
    localparam int RANDOM_WORDS_PER_PHASE = 10;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en;
    logic [3:0] cfg_write_data;
    int         fail_count;
    int         pending;

    // Stimulus bookkeeping. spl_now mirrors the register so that the line
    // generator can build indents that land on whole levels.
    int         words_sent;
    bit         sender_quiet;
    bit         hold_req;
    logic [3:0] spl_now;

    ikv_text_if  text_ch ();
    ikv_token_if token_ch ();

    indent_key_value_lexer_unit #(
        .MAX_INDENT(LEX_MAX_INDENT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .text          (text_ch),
        .token         (token_ch)
    );

    // The checker sits beside the block and only watches: it sees every word
    // on both channels and every register write.
    ikv_token_check #(
        .MAX_INDENT(LEX_MAX_INDENT)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .text          (text_ch),
        .token         (token_ch),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length between words or stall length on the receiver: mostly none or
    // short, now and then long. A quiet side never idles.
    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one word and returns at the edge where it is taken. The valid
    // line is left high, so a word that follows at once needs no second
    // assignment in the same step; anything that lets time pass without a
    // word must lower it first.
    task automatic send_word(logic [7:0] b, bit eot);
        int gap;
        gap = gap_len(sender_quiet);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!text_ch.ready);
        words_sent++;
    endtask

    // The byte is ignored by the block but still randomized.
    task automatic send_eot();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // Waits until every predicted token has left, then long enough for a word
    // that makes no token to finish inside the block.
    task automatic drain();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_spl(logic [3:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        spl_now = value;
    endtask

    // Content byte: mostly letters, with a fair share of the bytes the lexer
    // treats specially and of arbitrary values.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 19))
            0:       return CH_COLON;
            1:       return CH_DASH;
            2:       return CH_HASH;
            3:       return CH_BSLASH;
            4:       return CH_SPACE;
            5, 6:    return 8'($urandom_range(0, 255));
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // Byte after a backslash: each escape kind and a plain one.
    function automatic logic [7:0] escape_target();
        case ($urandom_range(0, 6))
            0:       return CH_COLON;
            1:       return CH_DASH;
            2:       return CH_HASH;
            3:       return CH_BSLASH;
            4:       return CH_NL;
            5:       return CH_SPACE;
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    task automatic send_key();
        repeat ($urandom_range(1, 4)) send_word(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
    endtask

    task automatic send_value(int max_len);
        repeat ($urandom_range(0, max_len)) send_word(pick_char(), 1'b0);
    endtask

    // One line of the format: indent, optional bullets, a body of one of several
    // shapes and the line break, sometimes a run of them or none at all.
    task automatic send_line();
        int eff;
        int lvl;
        int n_sp;
        int n_nl;
        eff = (spl_now == 4'd0) ? 1 : int'(spl_now);
        lvl = $urandom_range(0, 5);
        // Deep lines run into the indent ceiling; kept to narrow levels so
        // the space runs stay short.
        if (eff <= 2 && $urandom_range(0, 9) == 0)
            lvl = $urandom_range(12, 18);
        n_sp = lvl * eff;
        if ($urandom_range(0, 3) == 0)
            n_sp += $urandom_range(0, eff - 1);
        repeat (n_sp) send_word(CH_SPACE, 1'b0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_text("- ");
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                send_key();
                send_text(": ");
                send_value(5);
            end
            4:
            begin
                // Key whose colon is followed by the line break.
                send_key();
                send_word(CH_COLON, 1'b0);
            end
            5:
            begin
                send_word(CH_HASH, 1'b0);
                send_value(4);
            end
            6:
            begin
                send_key();
                repeat ($urandom_range(1, 3))
                begin
                    send_word(CH_BSLASH, 1'b0);
                    send_word(escape_target(), 1'b0);
                end
            end
            7:
            begin
                // Key-part colon with no space after it: a literal byte.
                send_key();
                send_word(CH_COLON, 1'b0);
                send_value(3);
            end
            8:
            begin
                repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            default:
            begin
                // Value carried on to the next line by backslash-newline.
                send_key();
                send_text("\\\n");
                send_value(4);
            end
        endcase
        n_nl = $urandom_range(0, 9);
        if (n_nl < 6)
            n_nl = 1;
        else if (n_nl < 9)
            n_nl = $urandom_range(2, 3);
        else
            n_nl = 0;
        repeat (n_nl) send_word(CH_NL, 1'b0);
    endtask

    // A document of a few lines, mostly closed by end of text. Some close at a
    // line start with spaces pending, some right after a backslash, and some
    // run on into the next document.
    task automatic send_doc();
        sender_quiet = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 3)) send_line();
        case ($urandom_range(0, 5))
            0:
            begin
                repeat ($urandom_range(1, 9)) send_word(CH_SPACE, 1'b0);
                send_eot();
            end
            1:
            begin
                send_word(CH_BSLASH, 1'b0);
                send_eot();
            end
            5:
            begin
            end
            default:
                send_eot();
        endcase
    endtask

    // One setting of spaces per level: random documents until the phase has
    // its share of words, then end of text so the block is idle again.
    task automatic run_phase(logic [3:0] spl, bit with_hold, bit with_pause);
        int start;
        write_spl(spl);
        if (with_hold)
            hold_req = 1'b1;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS_PER_PHASE)
        begin
            send_doc();
            if (with_pause && $urandom_range(0, 2) == 0)
                drain();
        end
        send_eot();
    endtask

    // Token receiver: ready in random runs with random stalls, quiet stretches
    // with no stall, and on request one long hold-off counted here.
    initial
    begin : token_sink
        bit quiet;
        int stall;
        token_ch.ready <= 1'b0;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                token_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    quiet = !quiet;
                token_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                stall = gap_len(quiet);
                if (stall > 0)
                begin
                    token_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= 8'h00;
        text_ch.end_of_text <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_write_data      <= 4'd0;
        words_sent   = 0;
        sender_quiet = 1'b0;
        hold_req     = 1'b0;
        spl_now      = ikv_pkg::SPL_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text at the reset setting of two spaces per level. It walks
        // through a key with colon-space, an indented bullet holding an escaped
        // colon and a backslash-newline continuation onto an empty line, a comment
        // line that drops the indent, a colon with no space that stays in the
        // string, a plain escape, the lowest and highest byte values, and a
        // backslash cut off by end of text.
        send_text("k: v\n  - \\:\\\n\n#z\na:b\\z");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_eot();

        // One space per level, with the receiver holding off for a long time
        // while text keeps coming, so the block fills and stalls its input.
        run_phase(4'd1, 1'b1, 1'b0);

        // Widest setting the phases use.
        run_phase(4'd8, 1'b0, 1'b0);

        // Zero is taken as one space per level.
        run_phase(4'd0, 1'b0, 1'b0);

        // Here the sender now and then stops until every token has come back.
        run_phase(4'd3, 1'b0, 1'b1);
        run_phase(4'd5, 1'b0, 1'b0);
        run_phase(ikv_pkg::SPL_RESET, 1'b0, 1'b0);

        drain();
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Far beyond the slowest correct run, long stalls included.
    initial
    begin : watchdog
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
